// ===== hw/rtl/lsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latching safety interlock package
// Shared types, codes and constants for the interlock sequencer and its
// searchable stores.
// ----------------------------------------------------------------------------
package lsi_pkg;

    // Default sizing of the stores and id fields.
    localparam int MAX_CAUSES_DEF    = 32;
    localparam int RETIRED_DEPTH_DEF = 32;
    localparam int ID_BITS_DEF       = 16;

    // Configuration port and field widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TIME_W     = 32;
    localparam int WIN_W      = 27;
    localparam int FIELD_ID_W = 16;
    localparam int CAUSE_W    = 8;

    // Signal values carried by a heartbeat.
    localparam logic [1:0] SIG_SAFE  = 2'd0;
    localparam logic [1:0] SIG_ALARM = 2'd1;
    localparam logic [1:0] SIG_FAULT = 2'd2;

    // Internal trip causes.
    localparam logic [CAUSE_W-1:0] CAUSE_ALARM    = 8'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_FAULT    = 8'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT  = 8'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_NOT_SAFE = 8'd4;

    typedef enum logic [1:0] {
        CMD_HEARTBEAT = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_TRIP      = 2'd2,
        CMD_RESET     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_INHIBITED = 2'd0,
        MODE_READY     = 2'd1,
        MODE_LATCHED   = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED         = 3'd0,
        CFG_HB_REQUIRED     = 3'd1,
        CFG_HB_TIMEOUT      = 3'd2,
        CFG_SAFE_READY      = 3'd3,
        CFG_SAFE_RESET      = 3'd4,
        CFG_EXPECTED_SOURCE = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        STS_ACCEPTED           = 5'd0,
        STS_SESSION_CHANGED    = 5'd1,
        STS_REPLAYED           = 5'd2,
        STS_INVALID_HEARTBEAT  = 5'd3,
        STS_UNEXPECTED_SOURCE  = 5'd4,
        STS_SOURCE_CHANGED     = 5'd5,
        STS_DISABLED           = 5'd6,
        STS_TRIPPED            = 5'd7,
        STS_ALREADY_LATCHED    = 5'd8,
        STS_INCIDENT_LATCHED   = 5'd9,
        STS_READY_NO_INTERLOCK = 5'd10,
        STS_AWAITING_INTERLOCK = 5'd11,
        STS_STABILIZING        = 5'd12,
        STS_READY              = 5'd13,
        STS_INVALID_INCIDENT   = 5'd14,
        STS_NOT_LATCHED        = 5'd15,
        STS_INCIDENT_MISMATCH  = 5'd16,
        STS_INVALID_AUDIT      = 5'd17,
        STS_NOT_SAFE           = 5'd18,
        STS_NOT_STABLE         = 5'd19,
        STS_RESET              = 5'd20,
        STS_GEN_EXHAUSTED      = 5'd21
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RET_WAIT,
        S_HB_APPLY,
        S_LATCH,
        S_CAUSE_WAIT,
        S_FINISH
    } t_lsi_state;

    // One command request.
    typedef struct packed {
        logic [1:0]            command;
        logic [TIME_W-1:0]     now_ms;
        logic [FIELD_ID_W-1:0] source_id;
        logic [FIELD_ID_W-1:0] session_id;
        logic [31:0]           sequence_number;
        logic [1:0]            signal;
        logic [CAUSE_W-1:0]    cause_code;
        logic [31:0]           incident_expected;
        logic [FIELD_ID_W-1:0] operator_id;
        logic                  reason_present;
    } t_lsi_req;

    // One result.
    typedef struct packed {
        logic [4:0]  status;
        logic        tripped;
        logic [1:0]  mode;
        logic        fresh_heartbeat;
        logic        reset_allowed;
        logic [31:0] incident_number;
        logic [5:0]  cause_count;
        logic [31:0] generation;
    } t_lsi_rsp;

    // Result of a store search.
    typedef struct packed {
        logic done;
        logic found;
    } t_lsi_srch_res;

endpackage

// ===== hw/rtl/lsi_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Searchable store
// A memory with an append/overwrite write port and a sequential
// key search that reads one entry per cycle over the filled entries.
// ----------------------------------------------------------------------------
module lsi_search #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WIDTH-1:0]      i_key,
    input  logic [CW-1:0]         i_count,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [WIDTH-1:0]      i_wr_data,
    output lsi_pkg::t_lsi_srch_res o_res
);
    import lsi_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;
    logic [WIDTH-1:0] r_key;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_pend;
    logic             r_found;
    logic             w_more;

    assign w_more = r_idx < r_cnt;

    // Memory write port and registered search read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (r_busy && w_more) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
        if (i_start) begin
            r_key <= i_key;
            r_cnt <= i_count;
        end
    end

    // Search control: one read issued and one compare made per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else if (r_busy) begin
            r_pend <= w_more;
            if (w_more) begin
                r_idx <= r_idx + CW'(1);
            end
            if (r_pend && (r_rd == r_key)) begin
                r_found <= 1'b1;
            end
            if (!w_more && !r_pend) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_res.done  = r_busy && !w_more && !r_pend;
    assign o_res.found = r_found;

endmodule

// ===== hw/rtl/latching_safety_interlock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latching safety interlock
// Heartbeat, tick, trip and reset sequencer with replay rejection, retired
// session ring, timeout and stability windows and a latched cause list.
// ----------------------------------------------------------------------------
// Sequence: a command that needs no search passes through S_DISPATCH and
// S_FINISH before its result is registered. The retired ring search (S_RET_WAIT)
// and the cause list search (S_CAUSE_WAIT) add to that where the command needs them.
// Flow: one request at a time; the input is taken again in S_IDLE, which the
// sequencer enters as the result is registered, and a stalled output register holds the sequencer.
// Reset: synchronous active-low reset restores the control and configuration registers and mode state.
// ----------------------------------------------------------------------------
module latching_safety_interlock #(
    parameter int MAX_CAUSES    = lsi_pkg::MAX_CAUSES_DEF,
    parameter int RETIRED_DEPTH = lsi_pkg::RETIRED_DEPTH_DEF,
    parameter int ID_BITS       = lsi_pkg::ID_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lsi_pkg::t_lsi_req                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lsi_pkg::t_lsi_rsp                 o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lsi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lsi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lsi_pkg::*;

    localparam int IdW  = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
    localparam int EntW = CAUSE_W + IdW;
    localparam int RAW  = (RETIRED_DEPTH > 1) ? $clog2(RETIRED_DEPTH) : 1;
    localparam int RCW  = $clog2(RETIRED_DEPTH + 1);
    localparam int CAW  = (MAX_CAUSES > 1) ? $clog2(MAX_CAUSES) : 1;
    localparam int CCW  = $clog2(MAX_CAUSES + 1);

    // Configuration registers.
    logic             r_enabled;
    logic             r_hb_req;
    logic [WIN_W-1:0] r_timeout;
    logic [WIN_W-1:0] r_safe_ready;
    logic [WIN_W-1:0] r_safe_reset;
    logic [IdW-1:0]   r_exp_src;

    // Interlock state.
    t_lsi_state         r_state, n_state;
    t_lsi_req           r_req, n_req;
    logic [1:0]         r_sig, n_sig;
    t_mode              r_mode, n_mode;
    logic               r_baseline, n_baseline;
    logic               r_seen, n_seen;
    logic [IdW-1:0]     r_cur_src, n_cur_src;
    logic [IdW-1:0]     r_cur_sess, n_cur_sess;
    logic [31:0]        r_last_seq, n_last_seq;
    logic [TIME_W-1:0]  r_hb_time, n_hb_time;
    logic [1:0]         r_last_sig, n_last_sig;
    logic               r_safe_valid, n_safe_valid;
    logic [TIME_W-1:0]  r_safe_time, n_safe_time;
    logic [RCW-1:0]     r_ret_cnt, n_ret_cnt;
    logic [RAW-1:0]     r_ret_wptr, n_ret_wptr;
    logic               r_inc_active, n_inc_active;
    logic [31:0]        r_inc_num, n_inc_num;
    logic [CCW-1:0]     r_held, n_held;
    logic [31:0]        r_gen, n_gen;
    logic               r_pfail, n_pfail;
    logic               r_retired, n_retired;
    t_status            r_status, n_status;
    logic               r_tripped, n_tripped;
    logic [CAUSE_W-1:0] r_lcause, n_lcause;
    logic [IdW-1:0]     r_lsrc, n_lsrc;
    logic               r_lfixed, n_lfixed;
    logic               r_out_valid, n_out_valid;
    t_lsi_rsp           r_out, n_out;

    // Store control.
    logic             w_rs_start, w_rs_wr;
    logic [RAW-1:0]   w_rs_addr;
    t_lsi_srch_res    w_rs_res;
    logic             w_cs_start, w_cs_wr;
    logic [CAW-1:0]   w_cs_addr;
    t_lsi_srch_res    w_cs_res;

    // Derived conditions.
    logic [IdW-1:0]    w_src, w_sess, w_op;
    logic [TIME_W-1:0] w_hb_age, w_safe_age;
    logic              w_fresh, w_safe_ready_ok, w_safe_reset_ok, w_reset_ok;
    logic              w_gen_full, w_same, w_chg, w_fin_latch, w_lchg;
    t_status           w_lstat;

    assign w_src  = r_req.source_id[IdW-1:0];
    assign w_sess = r_req.session_id[IdW-1:0];
    assign w_op   = r_req.operator_id[IdW-1:0];

    // Heartbeat freshness and safe windows at the request time.
    assign w_hb_age   = r_req.now_ms - r_hb_time;
    assign w_safe_age = r_req.now_ms - r_safe_time;
    assign w_fresh = r_seen && (r_req.now_ms >= r_hb_time) &&
                     (w_hb_age <= {{(TIME_W-WIN_W){1'b0}}, r_timeout});
    assign w_safe_ready_ok = r_safe_valid && (r_req.now_ms >= r_safe_time) &&
                     (w_safe_age >= {{(TIME_W-WIN_W){1'b0}}, r_safe_ready});
    assign w_safe_reset_ok = r_safe_valid && (r_req.now_ms >= r_safe_time) &&
                     (w_safe_age >= {{(TIME_W-WIN_W){1'b0}}, r_safe_reset});
    assign w_reset_ok = r_enabled && r_inc_active && (r_mode == MODE_LATCHED) &&
                     (!r_hb_req || (w_fresh && (r_last_sig == SIG_SAFE) &&
                                    w_safe_reset_ok));
    assign w_gen_full = (r_gen == '1);
    assign w_same     = r_seen && (w_sess == r_cur_sess);
    assign w_chg      = r_seen && !w_same;

    // Configuration writes.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b1;
            r_hb_req     <= 1'b1;
            r_timeout    <= WIN_W'(1000);
            r_safe_ready <= '0;
            r_safe_reset <= '0;
            r_exp_src    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLED:         r_enabled    <= i_cfg_data[0];
                CFG_HB_REQUIRED:     r_hb_req     <= i_cfg_data[0];
                CFG_HB_TIMEOUT:      r_timeout    <= i_cfg_data[WIN_W-1:0];
                CFG_SAFE_READY:      r_safe_ready <= i_cfg_data[WIN_W-1:0];
                CFG_SAFE_RESET:      r_safe_reset <= i_cfg_data[WIN_W-1:0];
                CFG_EXPECTED_SOURCE: r_exp_src    <= i_cfg_data[IdW-1:0];
                default: ;
            endcase
        end
    end

    // Retired session ring.
    lsi_search #(
        .DEPTH (RETIRED_DEPTH),
        .WIDTH (IdW)
    ) u_retired (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_rs_start),
        .i_key     (w_sess),
        .i_count   (r_ret_cnt),
        .i_wr_en   (w_rs_wr),
        .i_wr_addr (w_rs_addr),
        .i_wr_data (r_cur_sess),
        .o_res     (w_rs_res)
    );

    // Cause list of the active incident.
    lsi_search #(
        .DEPTH (MAX_CAUSES),
        .WIDTH (EntW)
    ) u_causes (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cs_start),
        .i_key     ({r_lcause, r_lsrc}),
        .i_count   (r_held),
        .i_wr_en   (w_cs_wr),
        .i_wr_addr (w_cs_addr),
        .i_wr_data ({r_lcause, r_lsrc}),
        .o_res     (w_cs_res)
    );

    // Sequencer next state and state updates.
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_sig        = r_sig;
        n_mode       = r_mode;
        n_baseline   = r_baseline;
        n_seen       = r_seen;
        n_cur_src    = r_cur_src;
        n_cur_sess   = r_cur_sess;
        n_last_seq   = r_last_seq;
        n_hb_time    = r_hb_time;
        n_last_sig   = r_last_sig;
        n_safe_valid = r_safe_valid;
        n_safe_time  = r_safe_time;
        n_ret_cnt    = r_ret_cnt;
        n_ret_wptr   = r_ret_wptr;
        n_inc_active = r_inc_active;
        n_inc_num    = r_inc_num;
        n_held       = r_held;
        n_gen        = r_gen;
        n_pfail      = r_pfail;
        n_retired    = r_retired;
        n_status     = r_status;
        n_tripped    = r_tripped;
        n_lcause     = r_lcause;
        n_lsrc       = r_lsrc;
        n_lfixed     = r_lfixed;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        w_rs_start   = 1'b0;
        w_rs_wr      = 1'b0;
        w_rs_addr    = (r_ret_cnt < RCW'(RETIRED_DEPTH)) ? r_ret_cnt[RAW-1:0] : r_ret_wptr;
        w_cs_start   = 1'b0;
        w_cs_wr      = 1'b0;
        w_cs_addr    = r_held[CAW-1:0];
        w_fin_latch  = 1'b0;
        w_lchg       = 1'b0;
        w_lstat      = STS_TRIPPED;

        unique case (r_state)
            // Take a request and fold an out-of-range signal onto fault.
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req     = i_in_data;
                    n_sig     = (i_in_data.signal > SIG_FAULT) ? SIG_FAULT
                                                               : i_in_data.signal;
                    n_tripped = 1'b0;
                    n_lfixed  = 1'b0;
                    n_state   = S_DISPATCH;
                end
            end

            // First decision on the command.
            S_DISPATCH: begin
                n_state = S_FINISH;
                unique case (r_req.command)
                    CMD_HEARTBEAT: begin
                        priority if (!r_enabled) begin
                            n_status = STS_DISABLED;
                        end else if ((w_src == '0) || (w_sess == '0)) begin
                            n_status = STS_INVALID_HEARTBEAT;
                        end else if ((r_exp_src != '0) && (w_src != r_exp_src)) begin
                            n_status = STS_UNEXPECTED_SOURCE;
                        end else if (r_seen && (w_src != r_cur_src)) begin
                            n_status = STS_SOURCE_CHANGED;
                        end else if (w_same) begin
                            n_retired = 1'b0;
                            n_state   = S_HB_APPLY;
                        end else begin
                            w_rs_start = 1'b1;
                            n_state    = S_RET_WAIT;
                        end
                    end
                    CMD_TICK: begin
                        priority if (!r_enabled) begin
                            n_mode   = MODE_READY;
                            n_status = STS_DISABLED;
                        end else if (r_mode == MODE_LATCHED) begin
                            n_tripped = 1'b1;
                            n_status  = STS_INCIDENT_LATCHED;
                            if (r_pfail) begin
                                if (w_gen_full) begin
                                    n_status = STS_GEN_EXHAUSTED;
                                end else begin
                                    n_gen   = r_gen + 32'd1;
                                    n_pfail = 1'b0;
                                end
                            end
                        end else if (r_hb_req && !r_seen) begin
                            n_mode   = MODE_INHIBITED;
                            n_status = STS_AWAITING_INTERLOCK;
                        end else if (r_hb_req && !w_fresh) begin
                            n_lcause = CAUSE_TIMEOUT;
                            n_lsrc   = r_cur_src;
                            n_state  = S_LATCH;
                        end else if (r_hb_req && (r_last_sig != SIG_SAFE)) begin
                            n_lcause = CAUSE_NOT_SAFE;
                            n_lsrc   = r_cur_src;
                            n_state  = S_LATCH;
                        end else if (r_hb_req && !w_safe_ready_ok) begin
                            n_mode   = MODE_INHIBITED;
                            n_status = STS_STABILIZING;
                        end else begin
                            // Ready, with the first baseline persist if needed.
                            n_status = r_hb_req ? STS_READY : STS_READY_NO_INTERLOCK;
                            n_pfail  = 1'b0;
                            n_mode   = MODE_READY;
                            if (!r_baseline) begin
                                if (w_gen_full) begin
                                    n_pfail  = 1'b1;
                                    n_mode   = MODE_INHIBITED;
                                    n_status = STS_GEN_EXHAUSTED;
                                end else begin
                                    n_baseline = 1'b1;
                                    n_gen      = r_gen + 32'd1;
                                end
                            end
                        end
                    end
                    CMD_TRIP: begin
                        priority if (!r_enabled) begin
                            n_status = STS_DISABLED;
                        end else if (r_req.cause_code == '0) begin
                            n_status = STS_INVALID_INCIDENT;
                        end else begin
                            n_lcause = r_req.cause_code;
                            n_lsrc   = w_src;
                            n_state  = S_LATCH;
                        end
                    end
                    CMD_RESET: begin
                        priority if (!r_enabled) begin
                            n_status = STS_DISABLED;
                        end else if (!r_inc_active || (r_mode != MODE_LATCHED)) begin
                            n_status = STS_NOT_LATCHED;
                        end else if (r_req.incident_expected != r_inc_num) begin
                            n_status = STS_INCIDENT_MISMATCH;
                        end else if ((w_op == '0) || !r_req.reason_present) begin
                            n_status = STS_INVALID_AUDIT;
                        end else if (r_hb_req &&
                                     (!w_fresh || (r_last_sig != SIG_SAFE))) begin
                            n_status = STS_NOT_SAFE;
                        end else if (r_hb_req && !w_safe_reset_ok) begin
                            n_status = STS_NOT_STABLE;
                        end else if (w_gen_full) begin
                            n_pfail  = 1'b1;
                            n_status = STS_GEN_EXHAUSTED;
                        end else begin
                            n_gen        = r_gen + 32'd1;
                            n_inc_active = 1'b0;
                            n_baseline   = 1'b1;
                            n_pfail      = 1'b0;
                            n_mode       = MODE_READY;
                            n_status     = STS_RESET;
                        end
                    end
                    default: ;
                endcase
            end

            // Wait for the retired session search.
            S_RET_WAIT: begin
                if (w_rs_res.done) begin
                    n_retired = w_rs_res.found;
                    n_state   = S_HB_APPLY;
                end
            end

            // Replay check, then take the heartbeat.
            S_HB_APPLY: begin
                n_lcause = (r_sig == SIG_ALARM) ? CAUSE_ALARM : CAUSE_FAULT;
                n_lsrc   = w_src;
                n_state  = S_FINISH;
                if ((w_same && (r_req.sequence_number <= r_last_seq)) || r_retired) begin
                    n_status = STS_REPLAYED;
                    if (r_sig != SIG_SAFE) begin
                        n_lfixed = 1'b1;
                        n_state  = S_LATCH;
                    end
                end else begin
                    if (w_chg) begin
                        // Retire the old session; a full ring drops its oldest.
                        w_rs_wr      = 1'b1;
                        n_safe_valid = 1'b0;
                        if (r_ret_cnt < RCW'(RETIRED_DEPTH)) begin
                            n_ret_cnt = r_ret_cnt + RCW'(1);
                        end else if (r_ret_wptr == RAW'(RETIRED_DEPTH - 1)) begin
                            n_ret_wptr = '0;
                        end else begin
                            n_ret_wptr = r_ret_wptr + RAW'(1);
                        end
                        if (r_hb_req && (r_mode == MODE_READY)) begin
                            n_mode = MODE_INHIBITED;
                        end
                    end
                    n_seen     = 1'b1;
                    n_cur_src  = w_src;
                    n_cur_sess = w_sess;
                    n_last_seq = r_req.sequence_number;
                    n_hb_time  = r_req.now_ms;
                    n_last_sig = r_sig;
                    if (r_sig == SIG_SAFE) begin
                        if ((r_last_sig != SIG_SAFE) || w_chg || !r_safe_valid) begin
                            n_safe_time  = r_req.now_ms;
                            n_safe_valid = 1'b1;
                        end
                        n_status = w_chg ? STS_SESSION_CHANGED : STS_ACCEPTED;
                    end else begin
                        n_safe_valid = 1'b0;
                        n_state      = S_LATCH;
                    end
                end
            end

            // Open a new incident or search the held causes.
            S_LATCH: begin
                if (!r_inc_active) begin
                    w_cs_wr      = 1'b1;
                    w_cs_addr    = '0;
                    n_held       = CCW'(1);
                    n_inc_active = 1'b1;
                    n_inc_num    = r_gen + 32'd1;
                    w_lchg       = 1'b1;
                    w_fin_latch  = 1'b1;
                end else begin
                    w_cs_start = 1'b1;
                    n_state    = S_CAUSE_WAIT;
                end
            end

            // Append a new cause while room is left.
            S_CAUSE_WAIT: begin
                if (w_cs_res.done) begin
                    w_fin_latch = 1'b1;
                    if (!w_cs_res.found && (r_held < CCW'(MAX_CAUSES))) begin
                        w_cs_wr = 1'b1;
                        n_held  = r_held + CCW'(1);
                        w_lchg  = 1'b1;
                    end
                end
            end

            // Move the result into the output register.
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status          = r_status;
                    n_out.tripped         = r_tripped;
                    n_out.mode            = r_mode;
                    n_out.fresh_heartbeat = w_fresh;
                    n_out.reset_allowed   = w_reset_ok;
                    n_out.incident_number = r_inc_active ? r_inc_num : 32'd0;
                    n_out.cause_count     = r_inc_active ? 6'(r_held) : 6'd0;
                    n_out.generation      = r_gen;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // Common end of a latch: persist when the incident changed or a
        // previous persist failed.
        if (w_fin_latch) begin
            n_baseline = 1'b1;
            n_mode     = MODE_LATCHED;
            n_tripped  = 1'b1;
            n_state    = S_FINISH;
            if (!w_lchg && !r_pfail) begin
                w_lstat = STS_ALREADY_LATCHED;
            end else if (w_gen_full) begin
                n_pfail = 1'b1;
                w_lstat = STS_GEN_EXHAUSTED;
            end else begin
                n_gen   = r_gen + 32'd1;
                n_pfail = 1'b0;
                w_lstat = STS_TRIPPED;
            end
            n_status = r_lfixed ? STS_REPLAYED : w_lstat;
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_INHIBITED;
            r_baseline   <= 1'b0;
            r_seen       <= 1'b0;
            r_cur_src    <= '0;
            r_cur_sess   <= '0;
            r_last_seq   <= '0;
            r_hb_time    <= '0;
            r_last_sig   <= SIG_FAULT;
            r_safe_valid <= 1'b0;
            r_safe_time  <= '0;
            r_ret_cnt    <= '0;
            r_ret_wptr   <= '0;
            r_inc_active <= 1'b0;
            r_inc_num    <= '0;
            r_held       <= '0;
            r_gen        <= '0;
            r_pfail      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_baseline   <= n_baseline;
            r_seen       <= n_seen;
            r_cur_src    <= n_cur_src;
            r_cur_sess   <= n_cur_sess;
            r_last_seq   <= n_last_seq;
            r_hb_time    <= n_hb_time;
            r_last_sig   <= n_last_sig;
            r_safe_valid <= n_safe_valid;
            r_safe_time  <= n_safe_time;
            r_ret_cnt    <= n_ret_cnt;
            r_ret_wptr   <= n_ret_wptr;
            r_inc_active <= n_inc_active;
            r_inc_num    <= n_inc_num;
            r_held       <= n_held;
            r_gen        <= n_gen;
            r_pfail      <= n_pfail;
            r_out_valid  <= n_out_valid;
        end
    end

    // Request working registers and output payload.
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_sig     <= n_sig;
        r_retired <= n_retired;
        r_status  <= n_status;
        r_tripped <= n_tripped;
        r_lcause  <= n_lcause;
        r_lsrc    <= n_lsrc;
        r_lfixed  <= n_lfixed;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== dv/latching_safety_interlock_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latching safety interlock testbench
// Drives heartbeat, tick, trip and reset requests through the interlock and
// checks every result against a cycle-free model of the mode, replay, window
// and incident logic. Runs a directed opening and then random traffic under
// several register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module latching_safety_interlock_tb;
    import lsi_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_CYC   = 100;
    localparam int RING_DEPTH   = 32;
    localparam int CAUSE_DEPTH  = 32;
    localparam int PHASE_ITEMS  = 240;
    localparam logic [31:0] GEN_TOP = 32'hFFFF_FFFF;

    // DUT connections.
    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    t_lsi_req        in_req = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    t_lsi_rsp        out_rsp;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    latching_safety_interlock i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Register copy.
    bit          cfg_en = 1'b1;
    bit          cfg_hb_req = 1'b1;
    logic [26:0] cfg_timeout = 27'd1000;
    logic [26:0] cfg_win_ready = '0;
    logic [26:0] cfg_win_reset = '0;
    logic [15:0] cfg_src = '0;

    // Interlock state copy.
    t_mode       st_mode = MODE_INHIBITED;
    bit          st_baseline, st_hb_seen, st_safe_valid, st_inc_active, st_persist_bad;
    logic [15:0] st_src = '0;
    logic [15:0] st_sess = '0;
    logic [15:0] st_rst_op = '0;
    logic [31:0] st_seq = '0;
    logic [31:0] st_hb_time = '0;
    logic [31:0] st_safe_time = '0;
    logic [31:0] st_inc_num = '0;
    logic [31:0] st_gen = '0;
    logic [31:0] st_rst_inc = '0;
    logic [1:0]  st_sig = SIG_FAULT;
    logic [15:0] st_retired [RING_DEPTH];
    int          st_ret_cnt;
    logic [23:0] st_causes [CAUSE_DEPTH];
    int          st_cause_cnt;
    bit          st_tripped;

    // Request and result queues.
    t_lsi_req    pending_reqs [$];
    t_lsi_rsp    expected_rsps [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          req_taken = 1'b0;
    int          send_gap = 0;
    int          hold_left = 0;
    bit          long_hold_req = 1'b0;
    bit          calm = 1'b0;

    // Stimulus cursor.
    logic [31:0] gen_now = 32'd1000;
    logic [15:0] gen_src = 16'hFFFF;
    logic [15:0] gen_sess = 16'd1;
    logic [31:0] gen_seq = '0;

    initial begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Interlock prediction
    // ------------------------------------------------------------------
    function automatic bit hb_fresh(logic [31:0] now);
        return st_hb_seen && now >= st_hb_time && (now - st_hb_time) <= {5'd0, cfg_timeout};
    endfunction

    function automatic bit safe_held(logic [31:0] now, logic [26:0] span);
        return st_safe_valid && now >= st_safe_time && (now - st_safe_time) >= {5'd0, span};
    endfunction

    function automatic bit reset_open(logic [31:0] now);
        return cfg_en && st_inc_active && st_mode == MODE_LATCHED &&
               (!cfg_hb_req || (hb_fresh(now) && st_sig == SIG_SAFE &&
                                safe_held(now, cfg_win_reset)));
    endfunction

    function automatic bit bump_generation();
        if (st_gen == GEN_TOP) return 1'b0;
        st_gen++;
        return 1'b1;
    endfunction

    function automatic t_status latch_cause(logic [7:0] cause, logic [15:0] src);
        logic [23:0] entry;
        bit grew;
        bit found;
        entry = {cause, src};
        grew = 1'b0;
        found = 1'b0;
        st_tripped = 1'b1;
        if (!st_inc_active) begin
            st_inc_active = 1'b1;
            st_inc_num = st_gen + 32'd1;
            st_causes[0] = entry;
            st_cause_cnt = 1;
            grew = 1'b1;
        end else begin
            for (int i = 0; i < st_cause_cnt; i++)
                if (st_causes[i] == entry) found = 1'b1;
            if (!found && st_cause_cnt < CAUSE_DEPTH) begin
                st_causes[st_cause_cnt] = entry;
                st_cause_cnt++;
                grew = 1'b1;
            end
        end
        st_baseline = 1'b1;
        st_mode = MODE_LATCHED;
        if (!grew && !st_persist_bad) return STS_ALREADY_LATCHED;
        if (!bump_generation()) begin
            st_persist_bad = 1'b1;
            return STS_GEN_EXHAUSTED;
        end
        st_persist_bad = 1'b0;
        return STS_TRIPPED;
    endfunction

    function automatic t_status go_ready(t_status ok_status);
        if (!st_baseline) begin
            st_baseline = 1'b1;
            if (!bump_generation()) begin
                st_baseline = 1'b0;
                st_persist_bad = 1'b1;
                st_mode = MODE_INHIBITED;
                return STS_GEN_EXHAUSTED;
            end
        end
        st_persist_bad = 1'b0;
        st_mode = MODE_READY;
        return ok_status;
    endfunction

    function automatic t_status apply_heartbeat(t_lsi_req r, logic [1:0] sig);
        bit same;
        bit retired;
        bit changed;
        logic [1:0] prev;
        if (!cfg_en) return STS_DISABLED;
        if (r.source_id == 0 || r.session_id == 0) return STS_INVALID_HEARTBEAT;
        if (cfg_src != 0 && r.source_id != cfg_src) return STS_UNEXPECTED_SOURCE;
        if (st_hb_seen && r.source_id != st_src) return STS_SOURCE_CHANGED;
        same = st_hb_seen && r.session_id == st_sess;
        retired = 1'b0;
        if (!same)
            for (int i = 0; i < st_ret_cnt; i++)
                if (st_retired[i] == r.session_id) retired = 1'b1;
        if ((same && r.sequence_number <= st_seq) || retired) begin
            if (sig != SIG_SAFE)
                void'(latch_cause(sig == SIG_ALARM ? CAUSE_ALARM : CAUSE_FAULT, r.source_id));
            return STS_REPLAYED;
        end
        changed = st_hb_seen && !same;
        if (changed) begin
            // The ring drops its oldest session once full.
            if (st_ret_cnt >= RING_DEPTH) begin
                for (int i = 0; i < RING_DEPTH - 1; i++) st_retired[i] = st_retired[i+1];
                st_retired[RING_DEPTH-1] = st_sess;
            end else begin
                st_retired[st_ret_cnt] = st_sess;
                st_ret_cnt++;
            end
            st_safe_valid = 1'b0;
            if (cfg_hb_req && st_mode == MODE_READY) st_mode = MODE_INHIBITED;
        end
        st_hb_seen = 1'b1;
        st_src = r.source_id;
        st_sess = r.session_id;
        st_seq = r.sequence_number;
        st_hb_time = r.now_ms;
        prev = st_sig;
        st_sig = sig;
        if (sig == SIG_SAFE) begin
            if (prev != SIG_SAFE || changed || !st_safe_valid) begin
                st_safe_time = r.now_ms;
                st_safe_valid = 1'b1;
            end
            return changed ? STS_SESSION_CHANGED : STS_ACCEPTED;
        end
        st_safe_valid = 1'b0;
        return latch_cause(sig == SIG_ALARM ? CAUSE_ALARM : CAUSE_FAULT, r.source_id);
    endfunction

    function automatic t_status apply_tick(logic [31:0] now);
        if (!cfg_en) begin
            st_mode = MODE_READY;
            return STS_DISABLED;
        end
        if (st_mode == MODE_LATCHED) begin
            st_tripped = 1'b1;
            // A latched tick retries a persist that failed earlier.
            if (st_persist_bad) begin
                if (!bump_generation()) return STS_GEN_EXHAUSTED;
                st_persist_bad = 1'b0;
            end
            return STS_INCIDENT_LATCHED;
        end
        if (!cfg_hb_req) return go_ready(STS_READY_NO_INTERLOCK);
        if (!st_hb_seen) begin
            st_mode = MODE_INHIBITED;
            return STS_AWAITING_INTERLOCK;
        end
        if (!hb_fresh(now)) return latch_cause(CAUSE_TIMEOUT, st_src);
        if (st_sig != SIG_SAFE) return latch_cause(CAUSE_NOT_SAFE, st_src);
        if (!safe_held(now, cfg_win_ready)) begin
            st_mode = MODE_INHIBITED;
            return STS_STABILIZING;
        end
        return go_ready(STS_READY);
    endfunction

    function automatic t_status apply_reset(t_lsi_req r);
        if (!cfg_en) return STS_DISABLED;
        if (!st_inc_active || st_mode != MODE_LATCHED) return STS_NOT_LATCHED;
        if (r.incident_expected != st_inc_num) return STS_INCIDENT_MISMATCH;
        if (r.operator_id == 0 || !r.reason_present) return STS_INVALID_AUDIT;
        if (cfg_hb_req && (!hb_fresh(r.now_ms) || st_sig != SIG_SAFE)) return STS_NOT_SAFE;
        if (cfg_hb_req && !safe_held(r.now_ms, cfg_win_reset)) return STS_NOT_STABLE;
        st_baseline = 1'b1;
        if (!bump_generation()) begin
            st_persist_bad = 1'b1;
            st_mode = MODE_LATCHED;
            return STS_GEN_EXHAUSTED;
        end
        st_inc_active = 1'b0;
        st_rst_inc = st_inc_num;
        st_rst_op = r.operator_id;
        st_persist_bad = 1'b0;
        st_mode = MODE_READY;
        return STS_RESET;
    endfunction

    function automatic t_lsi_rsp predict_result(t_lsi_req r);
        t_lsi_rsp res;
        t_status  sts;
        logic [1:0] sig;
        sig = (r.signal > SIG_FAULT) ? SIG_FAULT : r.signal;
        st_tripped = 1'b0;
        case (t_cmd'(r.command))
            CMD_HEARTBEAT: sts = apply_heartbeat(r, sig);
            CMD_TICK:      sts = apply_tick(r.now_ms);
            CMD_TRIP: begin
                if (!cfg_en) sts = STS_DISABLED;
                else if (r.cause_code == 0) sts = STS_INVALID_INCIDENT;
                else sts = latch_cause(r.cause_code, r.source_id);
            end
            default:       sts = apply_reset(r);
        endcase
        res.status          = sts;
        res.tripped         = st_tripped;
        res.mode            = st_mode;
        res.fresh_heartbeat = hb_fresh(r.now_ms);
        res.reset_allowed   = reset_open(r.now_ms);
        res.incident_number = st_inc_active ? st_inc_num : 32'd0;
        res.cause_count     = st_inc_active ? 6'(st_cause_cnt) : 6'd0;
        res.generation      = st_gen;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: changes on the falling edge.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !req_taken) begin
                // Hold the stalled request.
            end else if (send_gap > 0) begin
                req_taken = 1'b0;
                send_gap--;
                in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_taken = 1'b0;
                in_req <= pending_reqs.pop_front();
                in_valid <= 1'b1;
                if (calm) send_gap = 0;
                else if ($urandom_range(99) < 60) send_gap = 0;
                else if ($urandom_range(99) < 80) send_gap = $urandom_range(3, 1);
                else send_gap = $urandom_range(40, 5);
            end else begin
                req_taken = 1'b0;
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver stall.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (long_hold_req) begin
            // One long hold-off so the block backs up into its input.
            long_hold_req = 1'b0;
            hold_left = 300;
            out_stall <= 1'b1;
        end else if (calm) begin
            out_stall <= 1'b0;
        end else if ($urandom_range(99) < 3) begin
            hold_left = $urandom_range(40, 5);
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < 25);
        end
    end

    // Accepted requests are predicted; accepted results are checked.
    always @(posedge clk) begin
        t_lsi_rsp want;
        bit       moved;
        moved = 1'b0;
        if (rst_n && in_valid && !in_stall) begin
            expected_rsps.insert(expected_rsps.size(), predict_result(in_req));
            req_taken = 1'b1;
            moved = 1'b1;
        end
        if (rst_n && out_valid && !out_stall) begin
            moved = 1'b1;
            if (expected_rsps.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want = expected_rsps.pop_front();
                check_field("status", 32'(want.status), 32'(out_rsp.status));
                check_field("tripped", 32'(want.tripped), 32'(out_rsp.tripped));
                check_field("mode", 32'(want.mode), 32'(out_rsp.mode));
                check_field("fresh_heartbeat", 32'(want.fresh_heartbeat),
                            32'(out_rsp.fresh_heartbeat));
                check_field("reset_allowed", 32'(want.reset_allowed),
                            32'(out_rsp.reset_allowed));
                check_field("incident_number", want.incident_number, out_rsp.incident_number);
                check_field("cause_count", 32'(want.cause_count), 32'(out_rsp.cause_count));
                check_field("generation", want.generation, out_rsp.generation);
            end
        end
        if (cfg_valid && cfg_ready) moved = 1'b1;
        // Watchdog on cycles without any transfer.
        if (moved || !rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_ENABLED:     cfg_en = value[0];
            CFG_HB_REQUIRED: cfg_hb_req = value[0];
            CFG_HB_TIMEOUT:  cfg_timeout = value[26:0];
            CFG_SAFE_READY:  cfg_win_ready = value[26:0];
            CFG_SAFE_RESET:  cfg_win_reset = value[26:0];
            default:         cfg_src = value[15:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(bit en, bit hb_req, int tmo, int win_rdy, int win_rst,
                            logic [15:0] src);
        drain();
        repeat (SETTLE_CYC) @(posedge clk);
        write_reg(CFG_ENABLED, 32'(en));
        write_reg(CFG_HB_REQUIRED, 32'(hb_req));
        write_reg(CFG_HB_TIMEOUT, 32'(tmo));
        write_reg(CFG_SAFE_READY, 32'(win_rdy));
        write_reg(CFG_SAFE_RESET, 32'(win_rst));
        write_reg(CFG_EXPECTED_SOURCE, 32'(src));
    endtask

    function automatic t_lsi_req blank_req(t_cmd cmd);
        t_lsi_req r;
        r = '0;
        r.command = cmd;
        r.now_ms = gen_now;
        r.source_id = gen_src;
        r.operator_id = 16'd7;
        r.reason_present = 1'b1;
        r.incident_expected = st_inc_num;
        return r;
    endfunction

    function automatic t_lsi_req hb_req(logic [15:0] sess, logic [31:0] seq, logic [1:0] sig);
        t_lsi_req r;
        r = blank_req(CMD_HEARTBEAT);
        r.session_id = sess;
        r.sequence_number = seq;
        r.signal = sig;
        return r;
    endfunction

    task automatic send_one(t_lsi_req r);
        pending_reqs.insert(pending_reqs.size(), r);
        drain();
    endtask

    // Random request: about half are heartbeats, mostly well-formed and of the live session.
    function automatic t_lsi_req random_req();
        t_lsi_req r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            gen_now = $urandom();
        else if (pick < 5)
            gen_now = gen_now - $urandom_range(500);
        else if (pick < 20)
            gen_now = gen_now + $urandom_range(3000);
        else if (pick < 90)
            gen_now = gen_now + $urandom_range(600);
        pick = $urandom_range(99);
        if (pick < 50) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                gen_seq = gen_seq + $urandom_range(3, 1);
            end else if (pick < 88) begin
                gen_sess = 16'($urandom_range(16'hFFFF, 1));
                gen_seq = $urandom();
            end else if (pick < 93) begin
                gen_seq = gen_seq - $urandom_range(2);
            end else if (pick < 97 && st_ret_cnt > 0) begin
                gen_sess = st_retired[$urandom_range(st_ret_cnt - 1)];
                gen_seq = gen_seq + 32'd1;
            end
            pick = $urandom_range(99);
            r = hb_req(gen_sess, gen_seq,
                       pick < 80 ? SIG_SAFE : pick < 90 ? SIG_ALARM :
                       pick < 97 ? SIG_FAULT : 2'd3);
            pick = $urandom_range(99);
            if (pick < 4) r.source_id = 16'($urandom());
            else if (pick < 6) r.source_id = '0;
            else if (pick < 8) r.session_id = 16'($urandom_range(1));
        end else if (pick < 70) begin
            r = blank_req(CMD_TICK);
        end else if (pick < 80) begin
            r = blank_req(CMD_TRIP);
            pick = $urandom_range(99);
            r.cause_code = pick < 10 ? 8'd0 : pick < 40 ? 8'($urandom_range(4, 1)) :
                           8'($urandom());
            if ($urandom_range(1)) r.source_id = 16'($urandom());
        end else begin
            r = blank_req(CMD_RESET);
            if (!st_inc_active || $urandom_range(99) < 20) r.incident_expected = $urandom();
            r.operator_id = ($urandom_range(99) < 10) ? 16'd0 : 16'($urandom());
            r.reason_present = ($urandom_range(99) < 90);
        end
        // Unused fields carry noise.
        if (r.command != CMD_HEARTBEAT) begin
            r.session_id = 16'($urandom());
            r.sequence_number = $urandom();
            r.signal = 2'($urandom());
        end
        if (r.command != CMD_TRIP) r.cause_code = 8'($urandom());
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        t_lsi_req r;
        int chunk;
        int issued;
        in_req = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening under the reset register values.
        send_one(blank_req(CMD_TICK));
        r = hb_req(16'd1, 32'd1, SIG_SAFE); r.source_id = '0; send_one(r);
        send_one(hb_req(16'd0, 32'd1, SIG_SAFE));
        send_one(hb_req(16'd1, 32'd1, SIG_SAFE));
        gen_now += 10; send_one(blank_req(CMD_TICK));
        send_one(hb_req(16'd1, 32'd1, SIG_SAFE));
        send_one(hb_req(16'd2, 32'hFFFF_FFFF, SIG_SAFE));
        send_one(hb_req(16'd1, 32'd5, SIG_ALARM));
        r = hb_req(16'd2, 32'd9, SIG_SAFE); r.source_id = 16'h1234; send_one(r);
        r = blank_req(CMD_TRIP); r.cause_code = 8'd0; send_one(r);
        r = blank_req(CMD_TRIP); r.cause_code = 8'hFF; send_one(r);
        send_one(r);
        r.cause_code = CAUSE_NOT_SAFE; send_one(r);
        send_one(blank_req(CMD_TICK));
        r = blank_req(CMD_RESET); r.incident_expected = st_inc_num + 1; send_one(r);
        r = blank_req(CMD_RESET); r.operator_id = '0; send_one(r);
        r = blank_req(CMD_RESET); r.reason_present = 1'b0; send_one(r);
        gen_now += 20; send_one(hb_req(16'd3, 32'd0, SIG_SAFE));
        gen_now += 20; r = blank_req(CMD_RESET); r.operator_id = 16'hFFFF; send_one(r);
        send_one(blank_req(CMD_RESET));
        send_one(hb_req(16'd3, 32'd1, 2'd3));
        send_one(hb_req(16'd3, 32'd2, SIG_SAFE));
        r = blank_req(CMD_RESET); r.now_ms = gen_now - 10; send_one(r);
        send_one(blank_req(CMD_RESET));
        gen_now += 5000; send_one(blank_req(CMD_TICK));
        gen_sess = st_sess;
        gen_seq = st_seq;

        // Random phases under a range of register settings.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_regs(1, 1, 1000, 0, 0, 16'hFFFF);
                1: set_regs(1, 1, 86400000, 500, 300, 16'h0000);
                2: set_regs(1, 1, 1, 0, 0, 16'hFFFF);
                3: set_regs(0, 1, 1000, 0, 0, 16'h0000);
                4: set_regs(1, 0, 1000, 0, 0, 16'h0000);
                5: set_regs(1, 1, 2000, 86400000, 86400000, 16'hFFFF);
                6: set_regs(1, 1, 1500, 200, 200, 16'h0001);
                default: set_regs(1, 1, 800, 100, 0, 16'h0000);
            endcase
            issued = 0;
            while (issued < PHASE_ITEMS) begin
                chunk = $urandom_range(12, 1);
                calm = ($urandom_range(99) < 20);
                if (phase == 1 && issued == 0) begin
                    long_hold_req = 1'b1;
                    chunk = 12;
                end
                gen_sess = st_hb_seen ? st_sess : gen_sess;
                gen_seq = st_hb_seen ? st_seq : gen_seq;
                for (int k = 0; k < chunk; k++)
                    pending_reqs.insert(pending_reqs.size(), random_req());
                issued += chunk;
                drain();
            end
        end
        calm = 1'b0;

        drain();
        repeat (SETTLE_CYC) @(posedge clk);
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lsi_pkg.sv
hw/rtl/lsi_search.sv
hw/rtl/latching_safety_interlock.sv
dv/latching_safety_interlock_tb.sv
